@@ hdl/utf8v_pkg.sv @@
// Shared types, constants and helper functions of the UTF-8 field validator.
package utf8v_pkg;

  // Default COUNT_MAX; the code point counter saturates one past it.
  localparam int unsigned COUNT_MAX_DEF = 4095;

  // Fixed widths of the stream fields and registers.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 12;
  localparam int unsigned GLYPH_W = 13;
  localparam int unsigned POINT_W = 21;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BYTE_LIMIT  = 2'd0,
    CFG_POINT_LIMIT = 2'd1,
    CFG_FORBID_PIPE = 2'd2
  } cfg_idx_e;

  // Reset values of the configuration registers.
  localparam logic [LIMIT_W-1:0] BYTE_LIMIT_RST  = 12'd63;
  localparam logic [LIMIT_W-1:0] POINT_LIMIT_RST = 12'd0;
  localparam logic               FORBID_PIPE_RST = 1'b1;

  // Lead byte ranges, special lead bytes and continuation byte bounds.
  localparam logic [BYTE_W-1:0] ASCII_MAX  = 8'h7F;
  localparam logic [BYTE_W-1:0] LEAD2_MIN  = 8'hC2;
  localparam logic [BYTE_W-1:0] LEAD2_MAX  = 8'hDF;
  localparam logic [BYTE_W-1:0] LEAD3_MIN  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD3_MAX  = 8'hEF;
  localparam logic [BYTE_W-1:0] LEAD4_MIN  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD4_MAX  = 8'hF4;
  localparam logic [BYTE_W-1:0] LEAD_E0    = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_ED    = 8'hED;
  localparam logic [BYTE_W-1:0] LEAD_F0    = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD_F4    = 8'hF4;
  localparam logic [BYTE_W-1:0] CONT_A0    = 8'hA0;
  localparam logic [BYTE_W-1:0] CONT_90    = 8'h90;
  localparam logic [1:0]        CONT_TAG   = 2'b10;

  // Forbidden code points.
  localparam logic [POINT_W-1:0] CP_CTRL_END = 21'h00020;
  localparam logic [POINT_W-1:0] CP_DEL      = 21'h0007F;
  localparam logic [POINT_W-1:0] CP_PIPE     = 21'h0007C;

  // One input item as held in the input register.
  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              final_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph_count;
    logic               field_ok;
  } result_t;

  // White space here is Unicode Zs plus U+0085, U+2028, U+2029 and U+FEFF.
  function automatic logic is_space_point(input logic [POINT_W-1:0] cp);
    logic hit;
    hit = (cp == 21'h00020) || (cp == 21'h00085) || (cp == 21'h000A0) ||
          (cp == 21'h01680) || ((cp >= 21'h02000) && (cp <= 21'h0200A)) ||
          (cp == 21'h02028) || (cp == 21'h02029) || (cp == 21'h0202F) ||
          (cp == 21'h0205F) || (cp == 21'h03000) || (cp == 21'h0FEFF);
    return hit;
  endfunction

endpackage

@@ hdl/utf8v_in_reg.sv @@
// Input register stage of the UTF-8 field validator.
module utf8v_in_reg
  import utf8v_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  logic              take_i,
  output logic              valid_o,
  output item_t             item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // The register takes a request when empty or when its content moves on.
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.text_byte  <= in_byte_i;
      item_q.final_byte <= in_last_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  // A request is only moved on when one is held.
  a_take_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> valid_q)
    else $error("utf8v_in_reg: take without held request");

endmodule

@@ hdl/utf8v_check.sv @@
// Per-field decode state and strict UTF-8 checking of one byte per cycle while step_i is high.
module utf8v_check
  import utf8v_pkg::*;
#(
  parameter int unsigned COUNT_MAX = COUNT_MAX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  item_t              item_i,
  input  logic [LIMIT_W-1:0] byte_limit_i,
  input  logic [LIMIT_W-1:0] point_limit_i,
  input  logic               forbid_pipe_i,
  output result_t            result_o
);

  localparam int unsigned PCNT_W = $clog2(COUNT_MAX + 2);
  localparam logic [PCNT_W-1:0] PCNT_MAX = PCNT_W'(COUNT_MAX);

  logic                  failed_q, failed_d;
  logic [1:0]            pend_q, pend_d;
  logic [POINT_W-1:0]    part_q, part_d;
  logic [BYTE_W-1:0]     lead_q, lead_d;
  logic                  second_q, second_d;
  logic [LIMIT_W:0]      bcnt_q, bcnt_d;
  logic [PCNT_W-1:0]     pcnt_q, pcnt_d;
  logic                  nonsp_q, nonsp_d;

  logic                  finish;
  logic [POINT_W-1:0]    cp;
  logic                  bad_second;
  logic [BYTE_W-1:0]     b;
  logic [31:0]           pcnt_wide;

  assign b = item_i.text_byte;

  // Range checks on the first continuation byte after special lead bytes.
  assign bad_second = ((lead_q == LEAD_E0) && (b <  CONT_A0)) ||
                      ((lead_q == LEAD_ED) && (b >= CONT_A0)) ||
                      ((lead_q == LEAD_F0) && (b <  CONT_90)) ||
                      ((lead_q == LEAD_F4) && (b >= CONT_90));

  // Next state for the byte in the input register.
  always_comb begin
    failed_d = failed_q;
    pend_d   = pend_q;
    part_d   = part_q;
    lead_d   = lead_q;
    second_d = second_q;
    bcnt_d   = bcnt_q;
    pcnt_d   = pcnt_q;
    nonsp_d  = nonsp_q;
    finish   = 1'b0;
    cp       = '0;

    // Byte count saturates one past the limit.
    if (bcnt_q <= {1'b0, byte_limit_i}) begin
      bcnt_d = bcnt_q + 1'b1;
    end
    if (bcnt_d > {1'b0, byte_limit_i}) begin
      failed_d = 1'b1;
    end

    // Decode unless the field has already failed.
    if (!failed_d) begin
      if (pend_q == 2'd0) begin
        lead_d   = b;
        second_d = 1'b1;
        if (b <= ASCII_MAX) begin
          second_d = 1'b0;
          finish   = 1'b1;
          cp       = POINT_W'(b);
        end else if (b inside {[LEAD2_MIN:LEAD2_MAX]}) begin
          pend_d = 2'd1;
          part_d = POINT_W'(b[4:0]);
        end else if (b inside {[LEAD3_MIN:LEAD3_MAX]}) begin
          pend_d = 2'd2;
          part_d = POINT_W'(b[3:0]);
        end else if (b inside {[LEAD4_MIN:LEAD4_MAX]}) begin
          pend_d = 2'd3;
          part_d = POINT_W'(b[2:0]);
        end else begin
          second_d = 1'b0;
          failed_d = 1'b1;
        end
      end else if (b[7:6] != CONT_TAG) begin
        failed_d = 1'b1;
      end else if (second_q && bad_second) begin
        failed_d = 1'b1;
      end else begin
        second_d = 1'b0;
        part_d   = {part_q[POINT_W-7:0], b[5:0]};
        pend_d   = pend_q - 2'd1;
        if (pend_q == 2'd1) begin
          finish = 1'b1;
          cp     = {part_q[POINT_W-7:0], b[5:0]};
        end
      end
    end

    // A completed code point is screened, counted and classified.
    if (finish) begin
      if ((cp < CP_CTRL_END) || (cp == CP_DEL) || (forbid_pipe_i && (cp == CP_PIPE))) begin
        failed_d = 1'b1;
      end else begin
        if (pcnt_q <= PCNT_MAX) begin
          pcnt_d = pcnt_q + 1'b1;
        end
        if ((point_limit_i != '0) && (32'(pcnt_d) > 32'(point_limit_i))) begin
          failed_d = 1'b1;
        end else if (!is_space_point(cp)) begin
          nonsp_d = 1'b1;
        end
      end
    end

    // A failed field stops decoding.
    if (failed_d) begin
      pend_d   = 2'd0;
      second_d = 1'b0;
    end
  end

  // Result of the field, taken when the final byte steps.
  assign pcnt_wide            = 32'(pcnt_d);
  assign result_o.field_ok    = !failed_d && (pend_d == 2'd0) && nonsp_d;
  assign result_o.glyph_count = pcnt_wide[GLYPH_W-1:0];

  // Field state, cleared again after each final byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      failed_q <= 1'b0;
      pend_q   <= 2'd0;
      part_q   <= '0;
      lead_q   <= '0;
      second_q <= 1'b0;
      bcnt_q   <= '0;
      pcnt_q   <= '0;
      nonsp_q  <= 1'b0;
    end else if (step_i) begin
      if (item_i.final_byte) begin
        failed_q <= 1'b0;
        pend_q   <= 2'd0;
        part_q   <= '0;
        lead_q   <= '0;
        second_q <= 1'b0;
        bcnt_q   <= '0;
        pcnt_q   <= '0;
        nonsp_q  <= 1'b0;
      end else begin
        failed_q <= failed_d;
        pend_q   <= pend_d;
        part_q   <= part_d;
        lead_q   <= lead_d;
        second_q <= second_d;
        bcnt_q   <= bcnt_d;
        pcnt_q   <= pcnt_d;
        nonsp_q  <= nonsp_d;
      end
    end
  end

  // A failed field holds no sequence in progress.
  a_fail_clears_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> (pend_q == 2'd0) && !second_q)
    else $error("utf8v_check: sequence state left after failure");

  // The first-continuation flag only stands while continuation bytes are due.
  a_second_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> (pend_q != 2'd0))
    else $error("utf8v_check: first-continuation flag outside a sequence");

  // The code point counter never passes its saturation value.
  a_pcnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pcnt_q) <= (COUNT_MAX + 1))
    else $error("utf8v_check: code point counter beyond saturation");

endmodule

@@ hdl/utf8_field_validator.sv @@
// Top level of the UTF-8 field validator: configuration, stages and result register.
// The result of a final byte is registered once it leaves the input register.
// One byte per cycle unless a final byte waits; field state updates as each byte moves on.
// The input register keeps taking bytes while a result waits, until a final byte reaches it.
// Reset clears the stage valids and field state, and loads the register defaults.
module utf8_field_validator
  import utf8v_pkg::*;
#(
  parameter int unsigned COUNT_MAX = COUNT_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input stream: tdata holds text_byte; tlast is final_byte.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] text_byte
  input  logic                 s_axis_tlast,
  // Result stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // [0] field_ok, [13:1] glyph_count, [15:14] zero
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [LIMIT_W-1:0]   cfg_wdata_i
);

  logic [LIMIT_W-1:0] byte_limit_q;
  logic [LIMIT_W-1:0] point_limit_q;
  logic               forbid_pipe_q;

  logic    in_valid;
  item_t   item;
  logic    step;
  result_t result;
  logic    out_valid_q, out_valid_d;
  result_t out_q;
  logic    push;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_limit_q  <= BYTE_LIMIT_RST;
      point_limit_q <= POINT_LIMIT_RST;
      forbid_pipe_q <= FORBID_PIPE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BYTE_LIMIT:  byte_limit_q  <= cfg_wdata_i;
        CFG_POINT_LIMIT: point_limit_q <= cfg_wdata_i;
        CFG_FORBID_PIPE: forbid_pipe_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // A byte moves on unless it is final and the result register is blocked.
  assign step = in_valid && (!item.final_byte || !out_valid_q || m_axis_tready);
  assign push = step && item.final_byte;

  utf8v_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .take_i     (step),
    .valid_o    (in_valid),
    .item_o     (item)
  );

  utf8v_check #(
    .COUNT_MAX (COUNT_MAX)
  ) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .item_i        (item),
    .byte_limit_i  (byte_limit_q),
    .point_limit_i (point_limit_q),
    .forbid_pipe_i (forbid_pipe_q),
    .result_o      (result)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (push) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_q.glyph_count, out_q.field_ok};

  // A final byte that moves on always leaves a result behind.
  a_push_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> m_axis_tvalid)
    else $error("utf8_field_validator: final byte produced no result");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench of the UTF-8 field validator, with its own field decoder as predictor.
`timescale 1ns / 100ps

module testbench;
  import utf8v_pkg::*;

  localparam int unsigned COUNT_LIMIT = COUNT_MAX_DEF;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata = 8'd0;   // [7:0] text_byte
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [15:0]          m_axis_tdata;          // [0] field_ok, [13:1] glyph_count, [15:14] zero
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [LIMIT_W-1:0]   cfg_wdata_i = '0;

  utf8_field_validator i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  // 4 ns clock.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor copy of the configuration registers.
  logic [LIMIT_W-1:0] lim_bytes;
  logic [LIMIT_W-1:0] lim_points;
  logic               pipe_banned;

  // Predictor copy of the per-field decode state.
  logic               fld_failed;
  logic [1:0]         fld_pending;
  logic [POINT_W-1:0] fld_point;
  logic [7:0]         fld_lead;
  logic               fld_first_cont;
  logic [GLYPH_W-1:0] fld_bytes;
  logic [GLYPH_W-1:0] fld_points;
  logic               fld_has_glyph;

  // Verdicts still owed by the block, oldest first.
  result_t verdict_q[$];
  result_t want;

  // Bytes of the field being built for the next send.
  logic [7:0] field_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned bytes_sent = 0;
  int unsigned fields_sent = 0;
  int unsigned verdicts_ok = 0;
  int unsigned verdicts_bad = 0;

  // ---------------------------------------------------------------- predictor

  function automatic logic white_space(input logic [POINT_W-1:0] cp);
    case (cp)
      21'h00020, 21'h00085, 21'h000A0, 21'h01680, 21'h02028, 21'h02029,
      21'h0202F, 21'h0205F, 21'h03000, 21'h0FEFF: return 1'b1;
      default: return (cp >= 21'h02000) && (cp <= 21'h0200A);
    endcase
  endfunction

  function automatic void restart_field();
    fld_failed     = 1'b0;
    fld_pending    = 2'd0;
    fld_point      = '0;
    fld_lead       = 8'd0;
    fld_first_cont = 1'b0;
    fld_bytes      = '0;
    fld_points     = '0;
    fld_has_glyph  = 1'b0;
  endfunction

  // A complete code point: character class checks, then the count limit.
  function automatic void close_point(input logic [POINT_W-1:0] cp);
    if (cp < CP_CTRL_END || cp == CP_DEL || (pipe_banned && cp == CP_PIPE)) begin
      fld_failed = 1'b1;
      return;
    end
    if (fld_points <= COUNT_LIMIT) fld_points = fld_points + 1'b1;
    if (lim_points != 0 && fld_points > {1'b0, lim_points}) begin
      fld_failed = 1'b1;
      return;
    end
    if (!white_space(cp)) fld_has_glyph = 1'b1;
  endfunction

  // Strict UTF-8 decode of one byte of a field that has not failed yet.
  function automatic void decode_byte(input logic [7:0] b);
    if (fld_pending == 2'd0) begin
      fld_lead = b;
      fld_first_cont = 1'b1;
      if (b <= ASCII_MAX) begin
        fld_first_cont = 1'b0;
        close_point({13'd0, b});
      end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
        fld_pending = 2'd1;
        fld_point = {16'd0, b[4:0]};
      end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
        fld_pending = 2'd2;
        fld_point = {17'd0, b[3:0]};
      end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
        fld_pending = 2'd3;
        fld_point = {18'd0, b[2:0]};
      end else begin
        fld_first_cont = 1'b0;
        fld_failed = 1'b1;
      end
      return;
    end
    if (b[7:6] != CONT_TAG) begin
      fld_failed = 1'b1;
      return;
    end
    // The first continuation byte rules out overlongs, surrogates and points past U+10FFFF.
    if (fld_first_cont) begin
      if ((fld_lead == LEAD_E0 && b < CONT_A0) || (fld_lead == LEAD_ED && b >= CONT_A0) ||
          (fld_lead == LEAD_F0 && b < CONT_90) || (fld_lead == LEAD_F4 && b >= CONT_90)) begin
        fld_failed = 1'b1;
        return;
      end
      fld_first_cont = 1'b0;
    end
    fld_point = {fld_point[14:0], b[5:0]};
    fld_pending = fld_pending - 1'b1;
    if (fld_pending == 2'd0) close_point(fld_point);
  endfunction

  // One accepted request: byte limit, decode, and a verdict on the final byte.
  function automatic void validate_byte(input logic [7:0] b, input logic last);
    result_t v;
    if (fld_bytes <= {1'b0, lim_bytes}) fld_bytes = fld_bytes + 1'b1;
    if (fld_bytes > {1'b0, lim_bytes}) fld_failed = 1'b1;
    if (!fld_failed) decode_byte(b);
    if (fld_failed) begin
      fld_pending = 2'd0;
      fld_first_cont = 1'b0;
    end
    if (last) begin
      v.field_ok = !fld_failed && fld_pending == 2'd0 && fld_has_glyph;
      v.glyph_count = fld_points;
      verdict_q.push_back(v);
      restart_field();
    end
  endfunction

  // ---------------------------------------------------------------- monitors

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) validate_byte(s_axis_tdata, s_axis_tlast);
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  // Compare each accepted verdict with the oldest one predicted.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("verdict %h with none expected", m_axis_tdata));
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tdata[0] !== want.field_ok)
          report_mismatch($sformatf("field_ok %b, expected %b", m_axis_tdata[0], want.field_ok));
        if (m_axis_tdata[13:1] !== want.glyph_count)
          report_mismatch($sformatf("glyph_count %0d, expected %0d",
                                    m_axis_tdata[13:1], want.glyph_count));
        if (m_axis_tdata[15:14] !== 2'b00)
          report_mismatch($sformatf("padding bits %b not zero", m_axis_tdata[15:14]));
        if (want.field_ok) verdicts_ok++;
        else verdicts_bad++;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------- drivers

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
      default: begin send_idle_pct = 7; recv_stall_pct = 7; end
    endcase
  endtask

  // Send one request and hold it until the block takes it. Starts and ends at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    s_axis_tlast = last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_field();
    foreach (field_q[i]) send_byte(field_q[i], i == field_q.size() - 1);
    fields_sent++;
  endtask

  // Short field of up to four bytes, first byte in the highest of the n used lanes of the word.
  task automatic send_word(input logic [31:0] w, input int unsigned n);
    field_q.delete();
    for (int i = n - 1; i >= 0; i--) field_q.push_back(w[8*i +: 8]);
    send_field();
  endtask

  // Stop sending and wait until every predicted verdict has been taken.
  task automatic drain_verdicts();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tlast = 1'b0;
    while (verdict_q.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    if (verdict_q.size() != 0) begin
      report_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
      verdict_q.delete();
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [LIMIT_W-1:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    case (idx)
      CFG_BYTE_LIMIT:  lim_bytes = val;
      CFG_POINT_LIMIT: lim_points = val;
      CFG_FORBID_PIPE: pipe_banned = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // ---------------------------------------------------------------- field builders

  function automatic void push_point(input logic [POINT_W-1:0] cp);
    if (cp < 21'h80) begin
      field_q.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      field_q.push_back({3'b110, cp[10:6]});
      field_q.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      field_q.push_back({4'b1110, cp[15:12]});
      field_q.push_back({2'b10, cp[11:6]});
      field_q.push_back({2'b10, cp[5:0]});
    end else begin
      field_q.push_back({5'b11110, cp[20:18]});
      field_q.push_back({2'b10, cp[17:12]});
      field_q.push_back({2'b10, cp[11:6]});
      field_q.push_back({2'b10, cp[5:0]});
    end
  endfunction

  // A legal code point: often printable ASCII, with white space and all encoded lengths.
  function automatic logic [POINT_W-1:0] pick_sound_point();
    int unsigned r;
    logic [POINT_W-1:0] cp;
    r = $urandom_range(99);
    if (r < 45) begin
      cp = 21'($urandom_range(8'h7E, 8'h21));
    end else if (r < 55) begin
      case ($urandom_range(10))
        0: cp = 21'h00020;
        1: cp = 21'h00085;
        2: cp = 21'h000A0;
        3: cp = 21'h01680;
        4: cp = 21'h02028;
        5: cp = 21'h02029;
        6: cp = 21'h0202F;
        7: cp = 21'h0205F;
        8: cp = 21'h03000;
        9: cp = 21'h0FEFF;
        default: cp = 21'($urandom_range(21'h0200A, 21'h02000));
      endcase
    end else if (r < 70) begin
      cp = 21'($urandom_range(21'h7FF, 21'h80));
    end else if (r < 85) begin
      cp = 21'($urandom_range(21'hFFFF, 21'h800));
      // Keep clear of the surrogate block.
      if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h800;
    end else begin
      cp = 21'($urandom_range(21'h10FFFF, 21'h10000));
    end
    return cp;
  endfunction

  // One broken element: noise, control codes, surrogates, overlongs, out of range,
  // cut-off sequences and stray continuation bytes.
  function automatic void push_flaw();
    logic [POINT_W-1:0] cp;
    int unsigned start;
    int unsigned keep;
    case ($urandom_range(6))
      0: field_q.push_back(8'($urandom_range(255)));
      1: begin
        if ($urandom_range(3) == 0) field_q.push_back(8'h7F);
        else field_q.push_back(8'($urandom_range(31)));
      end
      2: push_point(21'($urandom_range(21'hDFFF, 21'hD800)));
      3: begin
        cp = 21'($urandom_range(21'hFFFF));
        case ($urandom_range(2))
          0: begin
            field_q.push_back({6'b110000, cp[7:6]});
            field_q.push_back({2'b10, cp[5:0]});
          end
          1: begin
            field_q.push_back(LEAD_E0);
            field_q.push_back({3'b100, cp[10:6]});
            field_q.push_back({2'b10, cp[5:0]});
          end
          default: begin
            field_q.push_back(LEAD_F0);
            field_q.push_back({4'b1000, cp[15:12]});
            field_q.push_back({2'b10, cp[11:6]});
            field_q.push_back({2'b10, cp[5:0]});
          end
        endcase
      end
      4: push_point(21'($urandom_range(21'h1FFFFF, 21'h110000)));
      5: begin
        start = field_q.size();
        push_point(21'($urandom_range(21'h10FFFF, 21'h80)));
        keep = $urandom_range(field_q.size() - start - 1, 1);
        while (field_q.size() > start + keep) void'(field_q.pop_back());
      end
      default: field_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
    endcase
  endfunction

  // Mostly well-formed fields of a few code points, some long ones, some with one flaw, some of random bytes.
  function automatic void build_field();
    int unsigned n;
    int unsigned flaw_at;
    field_q.delete();
    if ($urandom_range(19) == 0) begin
      n = $urandom_range(8, 1);
      repeat (n) field_q.push_back(8'($urandom_range(255)));
      return;
    end
    n = ($urandom_range(9) == 0) ? $urandom_range(70, 7) : $urandom_range(6, 1);
    flaw_at = ($urandom_range(3) == 0) ? $urandom_range(n - 1) : n;
    for (int i = 0; i < n; i++) begin
      if (i == flaw_at) push_flaw();
      else push_point(pick_sound_point());
    end
  endfunction

  // ---------------------------------------------------------------- tests

  // Field extremes and each decode rule under the reset configuration.
  task automatic test_decode_rules();
    set_idling(0);
    send_word(32'h41, 1);          // plain letter
    send_word(32'h20, 1);          // white space only
    send_word(32'h00, 1);          // lowest byte, a control code
    send_word(32'h7F, 1);          // DEL
    send_word(32'h7C, 1);          // pipe while forbidden
    send_word(32'hFF, 1);          // highest byte, never legal
    send_word(32'hC2A078, 3);      // no-break space followed by a letter
    send_word(32'hC080, 2);        // overlong two-byte form
    send_word(32'hE09F80, 3);      // overlong three-byte form
    send_word(32'hEDA080, 3);      // surrogate
    send_word(32'hF4908080, 4);    // above U+10FFFF
    send_word(32'hF0908080, 4);    // lowest four-byte point
    send_word(32'hE2C3A9, 3);      // lead byte inside a sequence
    send_word(32'hC3, 1);          // sequence cut off by the final byte
    drain_verdicts();
  endtask

  // Byte limit at zero, one and mid-range; both limits at top; small point limit; pipe allowed.
  task automatic test_limits();
    set_idling(3);
    write_reg(CFG_BYTE_LIMIT, 12'd0);
    send_word(32'h41, 1);
    send_word(32'h7879, 2);
    drain_verdicts();
    write_reg(CFG_BYTE_LIMIT, 12'd1);
    send_word(32'h41, 1);
    send_word(32'h4142, 2);
    drain_verdicts();
    write_reg(CFG_BYTE_LIMIT, 12'd4095);
    write_reg(CFG_POINT_LIMIT, 12'd4095);
    send_word(32'h41, 1);
    send_word(32'hF09F9880, 4);
    drain_verdicts();
    // Fields just at and just past the byte limit.
    write_reg(CFG_BYTE_LIMIT, 12'd24);
    set_idling(0);
    for (int len = 24; len <= 25; len++) begin
      field_q.delete();
      repeat (len) field_q.push_back(8'($urandom_range(8'h7E, 8'h21)));
      send_field();
    end
    drain_verdicts();
    set_idling(3);
    write_reg(CFG_POINT_LIMIT, 12'd2);
    send_word(32'h616263, 3);
    send_word(32'hC3A962, 3);
    drain_verdicts();
    write_reg(CFG_FORBID_PIPE, 12'd0);
    send_word(32'h7C, 1);
    send_word(32'h7C7F, 2);
    drain_verdicts();
    write_reg(CFG_FORBID_PIPE, 12'd1);
    write_reg(CFG_POINT_LIMIT, 12'd0);
    write_reg(CFG_BYTE_LIMIT, 12'd63);
  endtask

  // Random fields in phases, each with its own idling pattern and register settings.
  task automatic test_random_fields();
    int unsigned sent;
    logic [LIMIT_W-1:0] bl;
    logic [LIMIT_W-1:0] pl;
    for (int ph = 0; ph < 8; ph++) begin
      drain_verdicts();
      set_idling(ph % 4);
      case ($urandom_range(3))
        0: bl = 12'd4095;
        1: bl = 12'($urandom_range(40, 4));
        2: bl = 12'($urandom_range(4095));
        default: bl = ($urandom_range(3) == 0) ? 12'd0 : 12'd63;
      endcase
      case ($urandom_range(3))
        0: pl = 12'd0;
        1: pl = 12'($urandom_range(8, 1));
        2: pl = 12'd4095;
        default: pl = 12'($urandom_range(4095));
      endcase
      write_reg(CFG_BYTE_LIMIT, bl);
      write_reg(CFG_POINT_LIMIT, pl);
      write_reg(CFG_FORBID_PIPE, 12'($urandom_range(1)));
      sent = 0;
      while (sent < 50) begin
        build_field();
        sent += field_q.size();
        send_field();
      end
    end
    drain_verdicts();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    lim_bytes = BYTE_LIMIT_RST;
    lim_points = POINT_LIMIT_RST;
    pipe_banned = FORBID_PIPE_RST;
    restart_field();
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_decode_rules();
    test_limits();
    test_random_fields();
    repeat (10) @(negedge clk_i);

    $display("Summary: %0d bytes in %0d fields, %0d fields accepted and %0d rejected,",
             bytes_sent, fields_sent, verdicts_ok, verdicts_bad);
    $display("Summary: covering decode rules, limits, pipe setting and idling phases.");
    if (err_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
